>>> hdl/mtp_pkg.sv
// Shared types, constants and helper functions for the MT19937 generator.
// Used by every module of the block and by the mtp_word_if channel interface.
`default_nettype none

package mtp_pkg;

    // Generator geometry and the standard MT19937 constants.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned MT_WORDS = 624;
    localparam int unsigned MT_SHIFT = 397;
    localparam int unsigned IDX_W    = $clog2(MT_WORDS);

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(MT_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_FAR_WRAP = IDX_W'(MT_WORDS - MT_SHIFT);
    localparam logic [IDX_W-1:0] IDX_SHIFT    = IDX_W'(MT_SHIFT);
    localparam logic [IDX_W-1:0] IDX_BACK     = IDX_W'(MT_WORDS - MT_SHIFT);

    localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'd2567483615;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'd2636928640;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'd4022730752;
    localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;

    // A classified draw command as it travels through the queue.
    typedef struct packed {
        logic do_seed;
    } t_cmd;

    // One side of the command queue: a command and its valid flag.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_slot;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_RD1,
        ST_RD2,
        ST_CALC,
        ST_EMIT
    } t_back_state;

    // Output tempering of one state word.
    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & MT_TEMPER_B);
        t = t ^ ((t << 15) & MT_TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hdl/mtp_channels.sv
// Valid/ready channel interfaces for draw requests and result words.
// Depends on mtp_pkg for the word width.
`default_nettype none

interface mtp_draw_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

interface mtp_word_if;
    import mtp_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

>>> hdl/mtp_front.sv
// Front end: takes draw requests and classifies each as seeding or plain draw.
// Depends on mtp_pkg and the mtp_draw_if channel interface.
`default_nettype none

module mtp_front
    import mtp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mtp_draw_if.sink      i_draw,
    input  wire logic     i_q_full,
    output t_cmd_slot     o_push
);

    logic r_seed_pending;
    logic n_seed_pending;
    logic xfer;

    // A request transfers whenever the queue has room.
    assign i_draw.ready = !i_q_full;
    assign xfer         = i_draw.valid && !i_q_full;

    // The first draw after reset always seeds, as does any reseed request.
    assign o_push.valid       = xfer;
    assign o_push.cmd.do_seed = r_seed_pending || i_draw.reseed;

    assign n_seed_pending = xfer ? 1'b0 : r_seed_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_pending <= 1'b1;
        end else begin
            r_seed_pending <= n_seed_pending;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mtp_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on mtp_pkg for the command types.
`default_nettype none

module mtp_queue
    import mtp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_slot i_push,
    output logic           o_full,
    output t_cmd_slot      o_head,
    input  wire logic      i_pop_ready
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full      = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = o_head.valid && i_pop_ready;

    // Command storage; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/mtp_back.sv
// Back end: state memory, seeding sequencer, per-word twist, tempering and
// the output register. Depends on mtp_pkg and the mtp_word_if interface.
`default_nettype none

module mtp_back
    import mtp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [WORD_W-1:0] i_cfg_wr_data,
    input  wire t_cmd_slot         i_head,
    output logic                   o_pop_ready,
    mtp_word_if.source             o_word
);

    t_back_state r_state;
    t_back_state n_state;

    logic [WORD_W-1:0] r_mem [MT_WORDS];
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;

    logic [WORD_W-1:0] r_seed_value;
    logic [IDX_W-1:0]  r_word_index;
    logic [IDX_W-1:0]  r_seed_idx;
    logic [WORD_W-1:0] r_prev;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_new;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  rd_addr0;
    logic [IDX_W-1:0]  rd_addr1;
    logic              out_load;
    logic              out_free;

    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_far;
    logic [WORD_W-1:0] seed_mix;
    logic [WORD_W-1:0] seed_calc;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] twist_word;
    logic              seed_done;

    // Neighbor and far addresses of the current word, both modulo the state size.
    assign idx_next = (r_word_index == IDX_LAST) ? '0 : r_word_index + IDX_W'(1);
    assign idx_far  = (r_word_index < IDX_BACK) ? r_word_index + IDX_SHIFT
                                                : r_word_index - IDX_FAR_WRAP;

    // Initialization recurrence: one multiply per cycle from the previous word.
    assign seed_mix  = r_prev ^ (r_prev >> 30);
    assign seed_calc = (MT_INIT_MUL * seed_mix) + {{(WORD_W-IDX_W){1'b0}}, r_seed_idx};
    assign seed_word = (r_seed_idx == '0) ? r_seed_value : seed_calc;
    assign seed_done = (r_seed_idx == IDX_LAST);

    // Twist of one word: r_y holds the upper/lower mix, r_rd0 the far word.
    assign twist_word = r_rd0 ^ (r_y >> 1) ^ (r_y[0] ? MT_MATRIX : '0);

    assign out_free = !r_out_valid || o_word.ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = i_head.cmd.do_seed ? ST_SEED : ST_RD1;
                end
            end
            ST_SEED: begin
                if (seed_done) begin
                    n_state = ST_RD1;
                end
            end
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_CALC;
            ST_CALC: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-decoded controls for the memory and output register.
    always_comb begin
        o_pop_ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_word_index;
        mem_wdata   = twist_word;
        rd_addr0    = r_word_index;
        rd_addr1    = idx_next;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop_ready = 1'b1;
            ST_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = r_seed_idx;
                mem_wdata = seed_word;
            end
            ST_RD1:  rd_addr0 = r_word_index;
            ST_RD2:  rd_addr0 = idx_far;
            ST_CALC: mem_we = 1'b1;
            ST_EMIT: out_load = out_free;
            default: o_pop_ready = 1'b0;
        endcase
    end

    // State memory with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEED) begin
            r_prev <= seed_word;
        end
        if (r_state == ST_RD2) begin
            r_y <= (r_rd0 & MT_UPPER) | (r_rd1 & MT_LOWER);
        end
        if (r_state == ST_CALC) begin
            r_new <= twist_word;
        end
        if (out_load) begin
            r_out_word <= mt_temper(r_new);
        end
    end

    // Control registers: state, counters, seed register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_word_index <= '0;
            r_seed_idx   <= '0;
            r_seed_value <= SEED_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_seed_value <= i_cfg_wr_data;
            end
            if (r_state == ST_IDLE) begin
                r_seed_idx <= '0;
            end else if (r_state == ST_SEED) begin
                r_seed_idx <= r_seed_idx + IDX_W'(1);
            end
            if (r_state == ST_SEED && seed_done) begin
                r_word_index <= '0;
            end else if (r_state == ST_CALC) begin
                r_word_index <= idx_next;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.random_word = r_out_word;

endmodule

`default_nettype wire

>>> hdl/mersenne_twister_prng_top.sv
// MT19937 pseudo-random word generator, 32-bit tempered output.
//
// Channels: i_draw carries draw requests (valid, ready, reseed); o_word
// carries one 32-bit random_word per request, in request order. The seed
// register is written through i_cfg_wr_en / i_cfg_wr_data, by the user only
// while the block is idle (not enforced by the block); it resets to 5489.
// A two-entry command queue parts the request side from the engine, so
// requests transfer while a finished word waits at the output register.
// A plain draw runs the engine through ST_RD1, ST_RD2, ST_CALC and ST_EMIT:
// three reads on the two read ports of the state memory (current, next and
// far word), one write of the twisted word, and the tempered word loading
// the output register. The engine takes the next command only in ST_IDLE.
// A seeding draw (the first after reset, or reseed set) first writes all
// 624 state words, one per cycle.
// Reset clears the queue, the output valid flag and the index, and arms
// seeding for the next draw; the state memory is not cleared.
// When the receiver stalls, the word holds at the output, the engine waits
// with the next word, and requests transfer until the queue is full.
// Depends on mtp_pkg, mtp_channels, mtp_front, mtp_queue and mtp_back.
`default_nettype none

module mersenne_twister_prng_top
    import mtp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [WORD_W-1:0] i_cfg_wr_data,
    mtp_draw_if.sink               i_draw,
    mtp_word_if.source             o_word
);

    t_cmd_slot push;
    t_cmd_slot head;
    logic      q_full;
    logic      pop_ready;

    // Request acceptance and classification.
    mtp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_draw  (i_draw),
        .i_q_full(q_full),
        .o_push  (push)
    );

    // Command queue.
    mtp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (q_full),
        .o_head     (head),
        .i_pop_ready(pop_ready)
    );

    // Generator engine.
    mtp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_head       (head),
        .o_pop_ready  (pop_ready),
        .o_word       (o_word)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push.valid && q_full))
        else $error("command pushed into a full queue");

    // A reseed request always becomes a seeding command.
    a_reseed_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_draw.valid && i_draw.ready && i_draw.reseed) |->
            (push.valid && push.cmd.do_seed))
        else $error("reseed request not classified as seeding");

    // The engine takes a command only while it is idle and the queue holds one, then leaves idle.
    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head.valid && pop_ready) |=> !pop_ready)
        else $error("engine took a command without leaving idle");

endmodule

`default_nettype wire
